>>> rtl/core/quaternion_multiply_rotate_unit_macros.svh
// ----------------------------------------------------------------------------
// Quaternion multiply/rotate unit assertion macros
// Property shorthands used by the checker of this block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define QMR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qmr assertion failed");

// next-cycle implication, off during reset
`define QMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qmr assertion failed");

// next-cycle implication, also checked during reset
`define QMR_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qmr assertion failed");

`endif

>>> rtl/core/qmr_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion multiply/rotate package
// Shared constants, mode codes and stage enable struct.
// ----------------------------------------------------------------------------
package qmr_pkg;

  localparam int DEF_FRAC_BITS  = 13;
  localparam int DEF_COMP_WIDTH = 16;

  localparam int NUM_COMP   = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_COEF   = 9;
  localparam int NUM_STAGES = 5;

  // component order: x, y, z, w
  localparam int QX = 0;
  localparam int QY = 1;
  localparam int QZ = 2;
  localparam int QW = 3;

  typedef enum logic {
    MODE_PRODUCT = 1'b0,
    MODE_ROTATE  = 1'b1
  } mode_t;

  typedef struct packed {
    logic en_first;
    logic en_second;
  } stage_en_t;

  // index into the 4x4 product array
  function automatic int ix(input int i, input int j);
    return i * NUM_COMP + j;
  endfunction

endpackage

>>> rtl/core/qmr_rnd_sat.sv
// ----------------------------------------------------------------------------
// Round and saturate
// Round half up by FRAC_BITS, then clip to signed COMP_WIDTH.
// ----------------------------------------------------------------------------
module qmr_rnd_sat #(
  parameter int IN_W       = 34,
  parameter int FRAC_BITS  = 13,
  parameter int COMP_WIDTH = 16
) (
  input  logic signed [IN_W-1:0]       value,
  output logic signed [COMP_WIDTH-1:0] result,
  output logic                         clipped
);

  localparam logic signed [IN_W:0] HALF = (IN_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [IN_W:0] MAXV =
    {{(IN_W + 2 - COMP_WIDTH){1'b0}}, {(COMP_WIDTH - 1){1'b1}}};
  localparam logic signed [IN_W:0] MINV = ~MAXV;

  logic signed [IN_W:0] biased;
  logic signed [IN_W:0] shifted;

  assign biased  = $signed({value[IN_W-1], value}) + HALF;
  assign shifted = biased >>> FRAC_BITS;

  always_comb begin
    priority if (shifted > MAXV) begin
      result  = {1'b0, {(COMP_WIDTH - 1){1'b1}}};
      clipped = 1'b1;
    end else if (shifted < MINV) begin
      result  = {1'b1, {(COMP_WIDTH - 1){1'b0}}};
      clipped = 1'b1;
    end else begin
      result  = shifted[COMP_WIDTH-1:0];
      clipped = 1'b0;
    end
  end

endmodule

>>> rtl/core/qmr_prod_stage.sv
// ----------------------------------------------------------------------------
// Product stage
// Sixteen registered products a_i * b_j, or a_i * a_j for rotation.
// ----------------------------------------------------------------------------
module qmr_prod_stage import qmr_pkg::*; #(
  parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
  input  logic                           clk,
  input  logic                           en,
  input  mode_t                          mode,
  input  logic signed [COMP_WIDTH-1:0]   a [NUM_COMP],
  input  logic signed [COMP_WIDTH-1:0]   b [NUM_COMP],
  output logic signed [2*COMP_WIDTH-1:0] prod [NUM_COMP*NUM_COMP]
);

  logic signed [COMP_WIDTH-1:0] opnd [NUM_COMP];

  always_comb begin
    for (int j = 0; j < NUM_COMP; j++) begin
      opnd[j] = (mode == MODE_ROTATE) ? a[j] : b[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        for (int j = 0; j < NUM_COMP; j++) begin
          prod[ix(i, j)] <= a[i] * opnd[j];
        end
      end
    end
  end

endmodule

>>> rtl/core/qmr_mix_stage.sv
// ----------------------------------------------------------------------------
// Sum and round stages
// Exact sums of products (Hamilton terms or matrix coefficients), then
// round/saturate to the component format.
// ----------------------------------------------------------------------------
module qmr_mix_stage import qmr_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
  input  logic                           clk,
  input  stage_en_t                      en,
  input  mode_t                          mode,
  input  logic signed [2*COMP_WIDTH-1:0] prod [NUM_COMP*NUM_COMP],
  output logic signed [COMP_WIDTH-1:0]   coef [NUM_COEF],
  output logic                           clipped
);

  localparam int PW    = 2 * COMP_WIDTH;
  localparam int SUM_W = ((PW > 2 * FRAC_BITS + 1) ? PW : 2 * FRAC_BITS + 1) + 3;
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << (2 * FRAC_BITS);

  logic signed [SUM_W-1:0]      p [NUM_COMP*NUM_COMP];
  logic signed [SUM_W-1:0]      sum_next [NUM_COEF];
  logic signed [SUM_W-1:0]      sum [NUM_COEF];
  logic signed [COMP_WIDTH-1:0] rnd [NUM_COEF];
  logic [NUM_COEF-1:0]          clip;

  always_comb begin
    for (int k = 0; k < NUM_COMP * NUM_COMP; k++) begin
      p[k] = SUM_W'(prod[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      sum_next[k] = '0;
    end
    if (mode == MODE_ROTATE) begin
      sum_next[0] = ONE - ((p[ix(QY, QY)] + p[ix(QZ, QZ)]) <<< 1);
      sum_next[1] = (p[ix(QX, QY)] - p[ix(QZ, QW)]) <<< 1;
      sum_next[2] = (p[ix(QX, QZ)] + p[ix(QY, QW)]) <<< 1;
      sum_next[3] = (p[ix(QX, QY)] + p[ix(QZ, QW)]) <<< 1;
      sum_next[4] = ONE - ((p[ix(QX, QX)] + p[ix(QZ, QZ)]) <<< 1);
      sum_next[5] = (p[ix(QY, QZ)] - p[ix(QX, QW)]) <<< 1;
      sum_next[6] = (p[ix(QX, QZ)] - p[ix(QY, QW)]) <<< 1;
      sum_next[7] = (p[ix(QY, QZ)] + p[ix(QX, QW)]) <<< 1;
      sum_next[8] = ONE - ((p[ix(QX, QX)] + p[ix(QY, QY)]) <<< 1);
    end else begin
      sum_next[QX] = p[ix(QY, QZ)] - p[ix(QZ, QY)] + p[ix(QX, QW)] + p[ix(QW, QX)];
      sum_next[QY] = p[ix(QZ, QX)] - p[ix(QX, QZ)] + p[ix(QY, QW)] + p[ix(QW, QY)];
      sum_next[QZ] = p[ix(QX, QY)] - p[ix(QY, QX)] + p[ix(QZ, QW)] + p[ix(QW, QZ)];
      sum_next[QW] = p[ix(QW, QW)] - p[ix(QX, QX)] - p[ix(QY, QY)] - p[ix(QZ, QZ)];
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_first) begin
      sum <= sum_next;
    end
  end

  for (genvar k = 0; k < NUM_COEF; k++) begin : g_rnd
    qmr_rnd_sat #(
      .IN_W       (SUM_W),
      .FRAC_BITS  (FRAC_BITS),
      .COMP_WIDTH (COMP_WIDTH)
    ) u_rnd (
      .value   (sum[k]),
      .result  (rnd[k]),
      .clipped (clip[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en.en_second) begin
      coef    <= rnd;
      clipped <= |clip;
    end
  end

endmodule

>>> rtl/core/qmr_rot_stage.sv
// ----------------------------------------------------------------------------
// Matrix-vector stages
// Registered coefficient-by-vector products, then row sums, round/saturate
// and output selection.
// ----------------------------------------------------------------------------
module qmr_rot_stage import qmr_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int COMP_WIDTH = DEF_COMP_WIDTH
) (
  input  logic                         clk,
  input  stage_en_t                    en,
  input  mode_t                        mode,
  input  logic signed [COMP_WIDTH-1:0] coef [NUM_COEF],
  input  logic                         clipped,
  input  logic signed [COMP_WIDTH-1:0] vec [NUM_AXES],
  output logic signed [COMP_WIDTH-1:0] r [NUM_COMP],
  output logic                         saturated
);

  localparam int PW    = 2 * COMP_WIDTH;
  localparam int SUM_W = PW + 2;

  mode_t                        mode_d;
  logic                         clip_d;
  logic signed [COMP_WIDTH-1:0] pass_d [NUM_COMP];
  logic signed [PW-1:0]         mprod [NUM_COEF];
  logic signed [SUM_W-1:0]      acc [NUM_AXES];
  logic signed [COMP_WIDTH-1:0] rot [NUM_AXES];
  logic [NUM_AXES-1:0]          rot_clip;

  always_ff @(posedge clk) begin
    if (en.en_first) begin
      mode_d <= mode;
      clip_d <= clipped;
      for (int k = 0; k < NUM_COMP; k++) begin
        pass_d[k] <= coef[k];
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          mprod[i*NUM_AXES+j] <= coef[i*NUM_AXES+j] * vec[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      acc[i] = SUM_W'(mprod[i*NUM_AXES]) + SUM_W'(mprod[i*NUM_AXES+1])
             + SUM_W'(mprod[i*NUM_AXES+2]);
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_rnd
    qmr_rnd_sat #(
      .IN_W       (SUM_W),
      .FRAC_BITS  (FRAC_BITS),
      .COMP_WIDTH (COMP_WIDTH)
    ) u_rnd (
      .value   (acc[i]),
      .result  (rot[i]),
      .clipped (rot_clip[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en.en_second) begin
      if (mode_d == MODE_ROTATE) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          r[i] <= rot[i];
        end
        r[QW]     <= '0;
        saturated <= clip_d | (|rot_clip);
      end else begin
        r         <= pass_d;
        saturated <= clip_d;
      end
    end
  end

endmodule

>>> rtl/core/quaternion_multiply_rotate_unit.sv
// ----------------------------------------------------------------------------
// Quaternion multiply/rotate unit
// Hamilton product a*b, or rotation of vector b by quaternion a, in signed
// fixed point with round-half-up and saturation.
//
//   channel   dir  tdata                         tuser
//   s_axis    in   a_x a_y a_z a_w b_x b_y b_z b_w   mode
//   m_axis    out  r_x r_y r_z r_w                   saturated
//
// Five register stages: products, sums, round, matrix products, row sums.
// One transaction per cycle while the output is not stalled.
// rst clears the stage valid bits; data registers are not reset.
// A stalled output holds the pipeline only as far back as stages are full.
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate_unit import qmr_pkg::*; #(
  parameter  int FRAC_BITS  = DEF_FRAC_BITS,
  parameter  int COMP_WIDTH = DEF_COMP_WIDTH,
  localparam int IN_DATA_W  = 2 * NUM_COMP * COMP_WIDTH,
  localparam int OUT_DATA_W = ((NUM_COMP * COMP_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  input  logic                  s_axis_tuser,   // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // r_x, r_y, r_z, r_w, zero pad
  output logic                  m_axis_tuser    // saturated
);

  localparam int SIDE_STAGES = 3;

  logic [NUM_STAGES-1:0]           vld;
  logic [NUM_STAGES:0]             rdy;
  logic signed [COMP_WIDTH-1:0]    a [NUM_COMP];
  logic signed [COMP_WIDTH-1:0]    b [NUM_COMP];
  mode_t                           mode_q [SIDE_STAGES];
  logic signed [COMP_WIDTH-1:0]    vec_q [SIDE_STAGES][NUM_AXES];
  logic signed [2*COMP_WIDTH-1:0]  prod [NUM_COMP*NUM_COMP];
  logic signed [COMP_WIDTH-1:0]    coef [NUM_COEF];
  logic                            coef_clip;
  logic signed [COMP_WIDTH-1:0]    r [NUM_COMP];

  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      a[k] = s_axis_tdata[k*COMP_WIDTH +: COMP_WIDTH];
      b[k] = s_axis_tdata[(NUM_COMP+k)*COMP_WIDTH +: COMP_WIDTH];
    end
  end

  // stage i advances when empty or when the stage after it advances
  always_comb begin
    rdy[NUM_STAGES] = m_axis_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mode_q[0] <= mode_t'(s_axis_tuser);
      for (int k = 0; k < NUM_AXES; k++) begin
        vec_q[0][k] <= b[k];
      end
    end
    for (int s = 1; s < SIDE_STAGES; s++) begin
      if (rdy[s]) begin
        mode_q[s] <= mode_q[s-1];
        vec_q[s]  <= vec_q[s-1];
      end
    end
  end

  qmr_prod_stage #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_prod (
    .clk  (clk),
    .en   (rdy[0]),
    .mode (mode_t'(s_axis_tuser)),
    .a    (a),
    .b    (b),
    .prod (prod)
  );

  qmr_mix_stage #(
    .FRAC_BITS  (FRAC_BITS),
    .COMP_WIDTH (COMP_WIDTH)
  ) u_mix (
    .clk     (clk),
    .en      (stage_en_t'{en_first: rdy[1], en_second: rdy[2]}),
    .mode    (mode_q[0]),
    .prod    (prod),
    .coef    (coef),
    .clipped (coef_clip)
  );

  qmr_rot_stage #(
    .FRAC_BITS  (FRAC_BITS),
    .COMP_WIDTH (COMP_WIDTH)
  ) u_rot (
    .clk       (clk),
    .en        (stage_en_t'{en_first: rdy[3], en_second: rdy[4]}),
    .mode      (mode_q[SIDE_STAGES-1]),
    .coef      (coef),
    .clipped   (coef_clip),
    .vec       (vec_q[SIDE_STAGES-1]),
    .r         (r),
    .saturated (m_axis_tuser)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NUM_STAGES-1];

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < NUM_COMP; k++) begin
      m_axis_tdata[k*COMP_WIDTH +: COMP_WIDTH] = r[k];
    end
  end

endmodule

>>> rtl/core/qmr_checker.sv
// ----------------------------------------------------------------------------
// Quaternion multiply/rotate checker
// Port-level checks on reset, stall behavior and pipeline latency.
// ----------------------------------------------------------------------------
`include "quaternion_multiply_rotate_unit_macros.svh"

module qmr_checker #(
  parameter int OUT_DATA_W = 64
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  `QMR_ASSERT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid)

  `QMR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // input backs up only when every stage is full behind a stalled output
  `QMR_ASSERT_SAME(a_backpressure, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // an accepted transaction reaches the output while m_axis_tready stays high behind it
  `QMR_ASSERT_NEXT(a_latency, clk, rst, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid)

endmodule

bind quaternion_multiply_rotate_unit qmr_checker #(
  .OUT_DATA_W (OUT_DATA_W)
) u_qmr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
